>>> sv/pwo_pkg.sv
// ----------------------------------------------------------------------------
// Pulsar wavetable oscillator package
// Shared constants, the sequencer state type and the fixed-point helpers.
// ----------------------------------------------------------------------------
package pwo_pkg;

  localparam int TABLE_SIZE = 4096;
  localparam int NUM_TABLES = 8;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int TSEL_W     = $clog2(NUM_TABLES);
  localparam int STORE_DEPTH = NUM_TABLES * TABLE_SIZE;
  localparam logic [IDX_W-1:0] TABLE_LAST = IDX_W'(TABLE_SIZE - 1);
  localparam logic [32:0] PHASE_BOUND = 33'(TABLE_SIZE - 1) << 20;
  localparam int DIV_STEPS  = 47;

  localparam logic [2:0] CFG_PHASE_INC = 3'd0;
  localparam logic [2:0] CFG_MOD_INC   = 3'd1;
  localparam logic [2:0] CFG_MORPH_INC = 3'd2;
  localparam logic [2:0] CFG_NUM_WT    = 3'd3;
  localparam logic [2:0] CFG_NUM_WIN   = 3'd4;

  localparam logic [4:0] SEL_PULSE = 5'd16;
  localparam logic [4:0] SEL_MORPH = 5'd17;

  typedef enum logic [4:0] {
    S_IDLE, S_PW0, S_PW1, S_PW2, S_PWI, S_MPI, S_SEL, S_DIV,
    S_R0, S_R1, S_R2, S_R3, S_R4, S_IA, S_IB, S_FADE, S_PROD, S_FIN
  } state_t;

  // Cross-fade selection for one table stack.
  typedef struct packed {
    logic [TSEL_W-1:0] sel_a;
    logic [TSEL_W-1:0] sel_b;
    logic [14:0]       fr;
    logic              single;
  } stack_sel_t;

  // Linear interpolation between two Q1.15 entries at a Q.20 fraction,
  // rounded half up.
  function automatic logic signed [15:0] interp(input logic signed [15:0] t0,
                                                input logic signed [15:0] t1,
                                                input logic [19:0] fr);
    logic signed [16:0] d;
    logic signed [37:0] p;
    logic signed [38:0] v;
    d = $signed({t1[15], t1}) - $signed({t0[15], t0});
    p = d * $signed({1'b0, fr});
    v = $signed({{3{t0[15]}}, t0, 20'd0}) + $signed({p[37], p}) + 39'sd524288;
    return v[35:20];
  endfunction

  // Cross-fade between two stack values at a Q.15 fraction, rounded half up.
  function automatic logic signed [15:0] fade(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic [14:0] fr);
    logic signed [16:0] d;
    logic signed [32:0] p;
    logic signed [33:0] v;
    d = $signed({b[15], b}) - $signed({a[15], a});
    p = d * $signed({1'b0, fr});
    v = $signed({{3{a[15]}}, a, 15'd0}) + $signed({p[32], p}) + 34'sd16384;
    return v[30:15];
  endfunction

  // Table count clamped to 1..NUM_TABLES, minus one.
  function automatic logic [TSEL_W-1:0] count_m1(input logic [3:0] n);
    if (n == 4'd0) begin
      return '0;
    end else if (n > 4'(NUM_TABLES)) begin
      return TSEL_W'(NUM_TABLES - 1);
    end else begin
      return TSEL_W'(n - 4'd1);
    end
  endfunction

  function automatic stack_sel_t stack_select(input logic signed [15:0] mp,
                                              input logic [TSEL_W-1:0] nm1);
    logic signed [19:0] m;
    logic [2:0]         idx;
    stack_sel_t         r;
    m = mp * $signed({1'b0, nm1});
    if (m < 0) begin
      m = '0;
    end
    idx = m[17:15];
    r.fr = m[14:0];
    if (idx >= nm1) begin
      r.single = 1'b1;
      r.sel_a  = nm1;
      r.sel_b  = nm1;
    end else begin
      r.single = 1'b0;
      r.sel_a  = idx;
      r.sel_b  = idx + 3'd1;
    end
    return r;
  endfunction

endpackage

>>> sv/pwo_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module pwo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/pulsar_wavetable_oscillator_top.sv
// ----------------------------------------------------------------------------
// Pulsar wavetable oscillator
// Table loads and per-tick pulsar samples from four table memories.
// ----------------------------------------------------------------------------
//  channel  signals                                            direction
//  in       in_valid in_stall in_mode in_table_select          request in
//           in_table_index in_table_value
//  out      out_valid out_stall out_sample                     request out
//  cfg      cfg_we cfg_index cfg_wdata                         write only
//
// A table write completes in the cycle that accepts it. A tick runs the
// 47-step restoring divider that forms the table position, then the table
// reads; a tick whose pulse width is not positive skips both.
// Reset clears the phases and increments and sets both table counts to
// one; tables are undefined until written. A finished sample waits in the
// output register while the next request is taken; a tick stalls only at
// its end if that sample is still not taken.
// ----------------------------------------------------------------------------
module pulsar_wavetable_oscillator_top import pwo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [4:0]         in_table_select,
  input  logic [11:0]        in_table_index,
  input  logic signed [15:0] in_table_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  state_t state_r, state_nxt;

  logic [31:0] phase_inc_r, mod_inc_r;
  logic [22:0] morph_inc_r;
  logic [3:0]  num_wt_r, num_win_r;
  logic [31:0] wave_phase_r, pulse_phase_r;
  logic [22:0] morph_phase_r;

  logic signed [15:0] p0_r, p1_r, m0_r, m1_r, pw_r, mp_r;
  logic signed [15:0] wa0_r, wa1_r, wb0_r, wb1_r, ga0_r, ga1_r, gb0_r, gb1_r;
  logic signed [15:0] wa_r, wb_r, ga_r, gb_r, w_r, g_r, res_r;
  stack_sel_t         wsel_r, gsel_r;
  logic [46:0]        q_r;
  logic [14:0]        rem_r;
  logic [5:0]         cnt_r;
  logic               out_valid_r;
  logic signed [15:0] out_sample_r;

  logic               accept, load_out;
  logic [STORE_DEPTH == 0 ? 0 : $clog2(STORE_DEPTH)-1:0] wt_addr, win_addr;
  logic [IDX_W-1:0]   pwt_addr, mt_addr, pos_idx;
  logic               wt_we, win_we, pwt_we, mt_we;
  logic [15:0]        wt_rd, win_rd, pwt_rd, mt_rd;
  logic               pos_ok;

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign pos_idx    = q_r[31:20];
  assign pos_ok     = (q_r[46:32] == '0) && (q_r[31:20] != TABLE_LAST);

  pwo_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_wt_ram (
    .clk(clk), .we(wt_we), .addr(wt_addr), .wdata(in_table_value), .rdata(wt_rd));
  pwo_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_win_ram (
    .clk(clk), .we(win_we), .addr(win_addr), .wdata(in_table_value), .rdata(win_rd));
  pwo_ram #(.WIDTH(16), .DEPTH(TABLE_SIZE)) u_pwt_ram (
    .clk(clk), .we(pwt_we), .addr(pwt_addr), .wdata(in_table_value), .rdata(pwt_rd));
  pwo_ram #(.WIDTH(16), .DEPTH(TABLE_SIZE)) u_mt_ram (
    .clk(clk), .we(mt_we), .addr(mt_addr), .wdata(in_table_value), .rdata(mt_rd));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    wt_we     = 1'b0;
    win_we    = 1'b0;
    pwt_we    = 1'b0;
    mt_we     = 1'b0;
    wt_addr   = {wsel_r.sel_a, pos_idx};
    win_addr  = {gsel_r.sel_a, pos_idx};
    pwt_addr  = pulse_phase_r[31:20];
    mt_addr   = IDX_W'(morph_phase_r[22:20]);
    case (state_r)
      S_IDLE: begin
        wt_addr  = {in_table_select[TSEL_W-1:0], in_table_index};
        win_addr = {in_table_select[TSEL_W-1:0], in_table_index};
        pwt_addr = in_table_index;
        mt_addr  = in_table_index;
        if (accept) begin
          if (in_mode) begin
            wt_we  = (in_table_select < 5'd8);
            win_we = (in_table_select >= 5'd8) && (in_table_select < SEL_PULSE);
            pwt_we = (in_table_select == SEL_PULSE);
            mt_we  = (in_table_select == SEL_MORPH);
          end else begin
            state_nxt = S_PW0;
          end
        end
      end
      S_PW0: state_nxt = S_PW1;
      S_PW1: begin
        pwt_addr  = pulse_phase_r[31:20] + 12'd1;
        mt_addr   = IDX_W'(morph_phase_r[22:20]) + 12'd1;
        state_nxt = S_PW2;
      end
      S_PW2: state_nxt = S_PWI;
      S_PWI: state_nxt = S_MPI;
      S_MPI: state_nxt = (pw_r > 0) ? S_SEL : S_FIN;
      S_SEL: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          state_nxt = S_R0;
        end
      end
      S_R0: state_nxt = S_R1;
      S_R1: begin
        wt_addr   = {wsel_r.sel_a, pos_idx + 12'd1};
        win_addr  = {gsel_r.sel_a, pos_idx + 12'd1};
        state_nxt = S_R2;
      end
      S_R2: begin
        wt_addr   = {wsel_r.sel_b, pos_idx};
        win_addr  = {gsel_r.sel_b, pos_idx};
        state_nxt = S_R3;
      end
      S_R3: begin
        wt_addr   = {wsel_r.sel_b, pos_idx + 12'd1};
        win_addr  = {gsel_r.sel_b, pos_idx + 12'd1};
        state_nxt = S_R4;
      end
      S_R4:   state_nxt = S_IA;
      S_IA:   state_nxt = S_IB;
      S_IB:   state_nxt = S_FADE;
      S_FADE: state_nxt = S_PROD;
      S_PROD: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration and phase accumulators.
  logic [32:0] wave_sum, pulse_sum;
  logic [23:0] morph_sum, morph_bound;

  always_comb begin
    wave_sum = {1'b0, wave_phase_r} + {1'b0, phase_inc_r};
    if (wave_sum >= PHASE_BOUND) begin
      wave_sum = wave_sum - PHASE_BOUND;
    end
    pulse_sum = {1'b0, pulse_phase_r} + {1'b0, mod_inc_r};
    if (pulse_sum >= PHASE_BOUND) begin
      pulse_sum = pulse_sum - PHASE_BOUND;
    end
    // With a single wavetable the bound is zero and the phase just wraps.
    morph_bound = {1'b0, count_m1(num_wt_r), 20'd0};
    morph_sum   = {1'b0, morph_phase_r} + {1'b0, morph_inc_r};
    if (morph_sum >= morph_bound) begin
      morph_sum = morph_sum - morph_bound;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r   <= '0;
      mod_inc_r     <= '0;
      morph_inc_r   <= '0;
      num_wt_r      <= 4'd1;
      num_win_r     <= 4'd1;
      wave_phase_r  <= '0;
      pulse_phase_r <= '0;
      morph_phase_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PHASE_INC: phase_inc_r <= cfg_wdata;
          CFG_MOD_INC:   mod_inc_r   <= cfg_wdata;
          CFG_MORPH_INC: morph_inc_r <= cfg_wdata[22:0];
          CFG_NUM_WT:    num_wt_r    <= cfg_wdata[3:0];
          CFG_NUM_WIN:   num_win_r   <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (load_out) begin
        wave_phase_r  <= wave_sum[31:0];
        pulse_phase_r <= pulse_sum[31:0];
        morph_phase_r <= morph_sum[22:0];
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  logic [15:0]        rem_sh;
  logic [16:0]        rem_diff;
  logic signed [31:0] prod;
  logic signed [32:0] prod_rnd;
  logic signed [17:0] prod_sh;

  always_comb begin
    rem_sh   = {rem_r, q_r[46]};
    rem_diff = {1'b0, rem_sh} - {2'b00, pw_r[14:0]};
    prod     = w_r * g_r;
    prod_rnd = $signed({prod[31], prod}) + 33'sd16384;
    prod_sh  = prod_rnd[32:15];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_PW1: begin
        p0_r <= pwt_rd;
        m0_r <= mt_rd;
      end
      S_PW2: begin
        p1_r <= pwt_rd;
        m1_r <= mt_rd;
      end
      S_PWI: begin
        pw_r <= (pulse_phase_r[31:20] == TABLE_LAST) ? 16'sd0 :
                interp(p0_r, p1_r, pulse_phase_r[19:0]);
      end
      S_MPI: begin
        mp_r  <= interp(m0_r, m1_r, morph_phase_r[19:0]);
        res_r <= '0;
      end
      S_SEL: begin
        wsel_r <= stack_select(mp_r, count_m1(num_wt_r));
        gsel_r <= stack_select(mp_r, count_m1(num_win_r));
        q_r    <= {wave_phase_r, 15'd0};
        rem_r  <= '0;
        cnt_r  <= '0;
      end
      S_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        if (!rem_diff[16]) begin
          rem_r <= rem_diff[14:0];
          q_r   <= {q_r[45:0], 1'b1};
        end else begin
          rem_r <= rem_sh[14:0];
          q_r   <= {q_r[45:0], 1'b0};
        end
      end
      S_R1: begin
        wa0_r <= wt_rd;
        ga0_r <= win_rd;
      end
      S_R2: begin
        wa1_r <= wt_rd;
        ga1_r <= win_rd;
      end
      S_R3: begin
        wb0_r <= wt_rd;
        gb0_r <= win_rd;
      end
      S_R4: begin
        wb1_r <= wt_rd;
        gb1_r <= win_rd;
      end
      S_IA: begin
        wa_r <= pos_ok ? interp(wa0_r, wa1_r, q_r[19:0]) : 16'sd0;
        ga_r <= pos_ok ? interp(ga0_r, ga1_r, q_r[19:0]) : 16'sd0;
      end
      S_IB: begin
        wb_r <= pos_ok ? interp(wb0_r, wb1_r, q_r[19:0]) : 16'sd0;
        gb_r <= pos_ok ? interp(gb0_r, gb1_r, q_r[19:0]) : 16'sd0;
      end
      S_FADE: begin
        w_r <= wsel_r.single ? wa_r : fade(wa_r, wb_r, wsel_r.fr);
        g_r <= gsel_r.single ? ga_r : fade(ga_r, gb_r, gsel_r.fr);
      end
      S_PROD: begin
        if (prod_sh > 18'sd32767) begin
          res_r <= 16'sd32767;
        end else if (prod_sh < -18'sd32768) begin
          res_r <= -16'sd32768;
        end else begin
          res_r <= prod_sh[15:0];
        end
      end
      S_FIN: begin
        if (load_out) begin
          out_sample_r <= res_r;
        end
      end
      default: ;
    endcase
  end

endmodule
